>>> hw/rtl/bmwsc_pkg.sv
// Shared constants and types of the bus memory wait-state controller.
`default_nettype none

package bmwsc_pkg;

  // Memory geometry: each module is split into an even and an odd byte bank.
  localparam int ModuleBytes = 65536;
  localparam int ModuleCount = 2;
  localparam int ModuleAw    = $clog2(ModuleBytes);
  localparam int BankAw      = ModuleAw - 1;
  localparam int BankDepth   = ModuleBytes / 2;

  // Configuration port.
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int SizeW    = 17;

  localparam logic [CfgIdxW-1:0] RegIoHoleBase  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegIoHoleSize  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegModule0Base = 4'd2;
  localparam logic [CfgIdxW-1:0] RegModule0Size = 4'd3;
  localparam logic [CfgIdxW-1:0] RegModule1Base = 4'd4;
  localparam logic [CfgIdxW-1:0] RegModule1Size = 4'd5;
  localparam logic [CfgIdxW-1:0] RegLatency     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegRomFlags    = 4'd7;

  // Bus phase of the memory protocol.
  localparam logic [1:0] PhReady = 2'd0;
  localparam logic [1:0] PhRead  = 2'd1;
  localparam logic [1:0] PhWrite = 2'd2;
  localparam logic [1:0] PhClean = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the input transfer
    logic front;     // request decode and latch
    logic back;      // count, complete or clean up; issue bank access
    logic load_out;  // assemble the result into the output register
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/bmwsc_bank.sv
// One byte-wide memory bank with a shared address and registered read data.
`default_nettype none

module bmwsc_bank (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic                        re_i,
  input  wire logic [bmwsc_pkg::BankAw-1:0] addr_i,
  input  wire logic [7:0]                  wdata_i,
  output logic      [7:0]                  rdata_o
);

  logic [7:0] mem_q [bmwsc_pkg::BankDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/bmwsc_ctrl.sv
// Controller that sequences one bus clock item through the datapath.
`default_nettype none

module bmwsc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output bmwsc_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFront = 2'd1;
  localparam logic [1:0] StBack  = 2'd2;
  localparam logic [1:0] StFetch = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when it is empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.front    = 1'b0;
    cmd_o.back     = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StFront;
        end
      end
      StFront: begin
        cmd_o.front = 1'b1;
        state_d     = StBack;
      end
      StBack: begin
        cmd_o.back = 1'b1;
        state_d    = StFetch;
      end
      StFetch: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/bmwsc_dp.sv
// Datapath: configuration, bus phase state, address decode and memory banks.
`default_nettype none

module bmwsc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  bmwsc_pkg::cmd_t                    cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bmwsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bmwsc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          read_enable_i,
  input  wire logic [1:0]                    write_lanes_i,
  input  wire logic [31:0]                   bus_address_i,
  input  wire logic [15:0]                   write_data_i,
  output logic                               not_ready_o,
  output logic                               data_drive_o,
  output logic      [15:0]                   read_data_o
);

  localparam int Aw = bmwsc_pkg::ModuleAw;
  localparam int Bw = bmwsc_pkg::BankAw;
  localparam int Sw = bmwsc_pkg::SizeW;

  // Configuration registers.
  logic [31:0]   hole_base_q, hole_size_q, base0_q, base1_q, latency_q;
  logic [Sw-1:0] size0_q, size1_q;
  logic [1:0]    rom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_base_q <= '0;
      hole_size_q <= '0;
      base0_q     <= '0;
      size0_q     <= Sw'(65536);
      base1_q     <= 32'd65536;
      size1_q     <= Sw'(65536);
      latency_q   <= '0;
      rom_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bmwsc_pkg::RegIoHoleBase:  hole_base_q <= cfg_data_i;
        bmwsc_pkg::RegIoHoleSize:  hole_size_q <= cfg_data_i;
        bmwsc_pkg::RegModule0Base: base0_q     <= cfg_data_i;
        bmwsc_pkg::RegModule0Size: size0_q     <= cfg_data_i[Sw-1:0];
        bmwsc_pkg::RegModule1Base: base1_q     <= cfg_data_i;
        bmwsc_pkg::RegModule1Size: size1_q     <= cfg_data_i[Sw-1:0];
        bmwsc_pkg::RegLatency:     latency_q   <= cfg_data_i;
        bmwsc_pkg::RegRomFlags:    rom_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Region end addresses, computed in 33 bits so that they never wrap.
  logic [Sw-1:0] eff0, eff1;
  logic [32:0]   hole_end, end0, end1;

  assign eff0 = (size0_q > Sw'(bmwsc_pkg::ModuleBytes)) ? Sw'(bmwsc_pkg::ModuleBytes) : size0_q;
  assign eff1 = (size1_q > Sw'(bmwsc_pkg::ModuleBytes)) ? Sw'(bmwsc_pkg::ModuleBytes) : size1_q;

  assign hole_end = {1'b0, hole_base_q} + {1'b0, hole_size_q};
  assign end0     = {1'b0, base0_q} + {{(33 - Sw){1'b0}}, eff0};
  assign end1     = {1'b0, base1_q} + {{(33 - Sw){1'b0}}, eff1};

  // Captured input transfer.
  logic        in_rd_q;
  logic [1:0]  in_wr_q;
  logic [31:0] in_addr_q;
  logic [15:0] in_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_rd_q   <= read_enable_i;
      in_wr_q   <= write_lanes_i;
      in_addr_q <= bus_address_i;
      in_data_q <= write_data_i;
    end
  end

  // Bus protocol state.
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  wait_q, wait_d;
  logic [31:0] lat_addr_q, lat_addr_d;
  logic [15:0] lat_data_q, lat_data_d;
  logic [1:0]  lat_lanes_q, lat_lanes_d;
  logic        chosen_q, chosen_d;

  // Request decode.
  logic [31:0] addr_al;
  logic        req, hole_miss, hit0, hit1;
  logic [1:0]  lat_idx;
  logic [7:0]  lat_byte;

  assign addr_al   = {in_addr_q[31:1], 1'b0};
  assign req       = in_rd_q || (in_wr_q != 2'b00);
  assign hole_miss = (addr_al < hole_base_q) || ({1'b0, addr_al} >= hole_end);
  assign hit0      = (addr_al >= base0_q) && ({1'b0, addr_al} < end0);
  assign hit1      = (bmwsc_pkg::ModuleCount > 1) && (addr_al >= base1_q)
                     && ({1'b0, addr_al} < end1);
  assign lat_idx   = {~hit0, ~in_rd_q};
  assign lat_byte  = latency_q[{lat_idx, 3'b000} +: 8];

  // Completion checks against the chosen module.
  logic          busy, complete, comp_rd, comp_wr;
  logic [31:0]   mbase;
  logic [32:0]   mend, a1;
  logic          lo_ok, hi_ok, rom;
  logic [Aw-1:0] off_lo, off_hi;

  assign busy     = (phase_q == bmwsc_pkg::PhRead) || (phase_q == bmwsc_pkg::PhWrite);
  assign complete = cmd_i.back && busy && (wait_q == 8'd0);
  assign comp_rd  = complete && (phase_q == bmwsc_pkg::PhRead);
  assign comp_wr  = complete && (phase_q == bmwsc_pkg::PhWrite);
  assign mbase    = chosen_q ? base1_q : base0_q;
  assign mend     = chosen_q ? end1 : end0;
  assign a1       = {1'b0, lat_addr_q} + 33'd1;
  assign lo_ok    = (lat_addr_q >= mbase) && ({1'b0, lat_addr_q} < mend);
  assign hi_ok    = (a1 >= {1'b0, mbase}) && (a1 < mend);
  assign rom      = rom_q[chosen_q];
  assign off_lo   = lat_addr_q[Aw-1:0] - mbase[Aw-1:0];
  assign off_hi   = off_lo + Aw'(1);

  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    lat_addr_d  = lat_addr_q;
    lat_data_d  = lat_data_q;
    lat_lanes_d = lat_lanes_q;
    chosen_d    = chosen_q;
    if (cmd_i.front && (phase_q == bmwsc_pkg::PhReady) && req) begin
      lat_addr_d  = addr_al;
      lat_data_d  = in_data_q;
      lat_lanes_d = in_wr_q;
      if (hole_miss && (hit0 || hit1)) begin
        chosen_d = ~hit0;
        phase_d  = in_rd_q ? bmwsc_pkg::PhRead : bmwsc_pkg::PhWrite;
        wait_d   = lat_byte;
      end
    end
    if (cmd_i.back) begin
      if (busy) begin
        if (wait_q != 8'd0) begin
          wait_d = wait_q - 8'd1;
        end else begin
          phase_d = bmwsc_pkg::PhClean;
        end
      end else if (phase_q == bmwsc_pkg::PhClean) begin
        phase_d = bmwsc_pkg::PhReady;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bmwsc_pkg::PhReady;
      wait_q      <= '0;
      lat_addr_q  <= '0;
      lat_data_q  <= '0;
      lat_lanes_q <= '0;
      chosen_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      lat_addr_q  <= lat_addr_d;
      lat_data_q  <= lat_data_d;
      lat_lanes_q <= lat_lanes_d;
      chosen_q    <= chosen_d;
    end
  end

  // Per-clock result parts, captured with the bank access.
  logic nr_q, drive_q, lo_ok_q, hi_ok_q, lo_odd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.back) begin
      nr_q     <= busy && (wait_q != 8'd0);
      drive_q  <= comp_rd;
      lo_ok_q  <= lo_ok;
      hi_ok_q  <= hi_ok;
      lo_odd_q <= off_lo[0];
    end
  end

  // Each module has an even and an odd bank; the two bytes of a halfword
  // always fall in different banks.
  logic [7:0] bank_rdata [2][2];

  for (genvar m = 0; m < 2; m++) begin : g_module
    for (genvar p = 0; p < 2; p++) begin : g_bank
      logic          lo_here, we, re;
      logic [Bw-1:0] addr;
      logic [7:0]    wdata;

      assign lo_here = (off_lo[0] == 1'(p));
      assign addr    = lo_here ? off_lo[Aw-1:1] : off_hi[Aw-1:1];
      assign wdata   = lo_here ? lat_data_q[7:0] : lat_data_q[15:8];
      assign we      = comp_wr && (chosen_q == 1'(m)) && !rom
                       && (lo_here ? (lat_lanes_q[0] && lo_ok) : (lat_lanes_q[1] && hi_ok));
      assign re      = comp_rd && (chosen_q == 1'(m));

      bmwsc_bank u_bank (
        .clk_i   (clk_i),
        .we_i    (we),
        .re_i    (re),
        .addr_i  (addr),
        .wdata_i (wdata),
        .rdata_o (bank_rdata[m][p])
      );
    end
  end

  // Result assembly and output register.
  logic [7:0]  lo_byte, hi_byte;
  logic [15:0] rdata;
  logic        not_ready_q, data_drive_q;
  logic [15:0] read_data_q;

  assign lo_byte = bank_rdata[chosen_q][lo_odd_q];
  assign hi_byte = bank_rdata[chosen_q][~lo_odd_q];
  assign rdata   = drive_q ? {hi_ok_q ? hi_byte : 8'h00, lo_ok_q ? lo_byte : 8'h00} : 16'h0000;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      not_ready_q  <= nr_q;
      data_drive_q <= drive_q;
      read_data_q  <= rdata;
    end
  end

  assign not_ready_o  = not_ready_q;
  assign data_drive_o = data_drive_q;
  assign read_data_o  = read_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/bus_memory_wait_state_ctrl.sv
// Bus memory controller with wait states: two byte-addressed memory modules.
//
// Each input transfer is one bus clock: read enable, two write byte lanes,
// byte address and 16-bit write data. Each transfer yields exactly one result
// transfer: the not-ready wait flag, the data-drive flag and the little-endian
// read halfword (zero unless data is driven). Requests are latched only in the
// ready phase, counted down through the module's read or write latency and
// then completed, followed by one cleanup clock.
// Configuration registers are written through the plain write port while no
// transfer is in flight; they take effect for transfers accepted afterward.
// Sequence: decode, bank access and result assembly follow the capture of an
// input transfer, after which the result is registered. The next input is
// taken in the cycle after the result is assembled, never while one is in flight.
// The registered read port of the memory banks makes assembly a separate step.
// A stalled result holds in the output register; the block then accepts one
// more input and stops before assembling its result until the slot frees.
// Reset clears the configuration to its defaults and the bus phase to ready.
// Memory contents are undefined until written and are not cleared.
`default_nettype none

module bus_memory_wait_state_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bmwsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bmwsc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          read_enable_i,
  input  wire logic [1:0]                    write_lanes_i,
  input  wire logic [31:0]                   bus_address_i,
  input  wire logic [15:0]                   write_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               not_ready_o,
  output logic                               data_drive_o,
  output logic      [15:0]                   read_data_o
);

  bmwsc_pkg::cmd_t cmd;

  bmwsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bmwsc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .read_enable_i (read_enable_i),
    .write_lanes_i (write_lanes_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .not_ready_o   (not_ready_o),
    .data_drive_o  (data_drive_o),
    .read_data_o   (read_data_o)
  );

endmodule

`default_nettype wire

>>> tb/bus_memory_wait_state_ctrl_test.sv
// Self-checking testbench of the bus memory wait-state controller.
module bus_memory_wait_state_ctrl_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems  = 325;
  localparam int PhaseCount  = 6;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 600000;
  localparam int PlanRows    = 29;

  typedef struct {
    bit        rd;
    bit [1:0]  lanes;
    bit [31:0] addr;
    bit [15:0] data;
  } bus_req_t;

  typedef struct {
    bit        nr;
    bit        drive;
    bit [15:0] rdata;
  } bus_out_t;

  typedef struct {
    bit [31:0] hole_base;
    bit [31:0] hole_size;
    bit [31:0] m0_base;
    bit [16:0] m0_size;
    bit [31:0] m1_base;
    bit [16:0] m1_size;
    bit [31:0] latency;
    bit [1:0]  rom;
  } mem_map_t;

  typedef struct {
    bit                            is_reg;
    logic [bmwsc_pkg::CfgIdxW-1:0] idx;
    bit [31:0]                     val;
    bus_req_t                      req;
    bit                            typed;
    bus_out_t                      out;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [bmwsc_pkg::CfgIdxW-1:0]  cfg_index_i   = bmwsc_pkg::RegIoHoleBase;
  logic [bmwsc_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic                           read_enable_i = 1'b0;
  logic [1:0]                     write_lanes_i = 2'b00;
  logic [31:0]                    bus_address_i = '0;
  logic [15:0]                    write_data_i  = '0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic                           not_ready_o;
  logic                           data_drive_o;
  logic [15:0]                    read_data_o;

  bus_memory_wait_state_ctrl u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .read_enable_i (read_enable_i),
    .write_lanes_i (write_lanes_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .not_ready_o   (not_ready_o),
    .data_drive_o  (data_drive_o),
    .read_data_o   (read_data_o)
  );

  // Model of the controller, starting from its reset state.
  mem_map_t    cfg = '{32'h0, 32'h0, 32'h0, 17'h10000, 32'h0001_0000, 17'h10000, 32'h0, 2'b00};
  logic [1:0]  bus_phase  = bmwsc_pkg::PhReady;
  bit [7:0]    wait_cnt   = '0;
  bit [31:0]   held_addr  = '0;
  bit [15:0]   held_data  = '0;
  bit [1:0]    held_lanes = '0;
  bit          held_module = 1'b0;
  bit [7:0]    mem_bytes [2][bmwsc_pkg::ModuleBytes];
  bit          written   [2][bmwsc_pkg::ModuleBytes];

  bus_out_t    awaited_out [$];
  int          fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void queue_result(bus_out_t r);
    awaited_out.insert(awaited_out.size(), r);
  endfunction

  function automatic bit [16:0] eff_size(bit m);
    bit [16:0] s;
    s = m ? cfg.m1_size : cfg.m0_size;
    return (s > 17'h10000) ? 17'h10000 : s;
  endfunction

  function automatic bit [33:0] base_of(bit m);
    return m ? {2'b00, cfg.m1_base} : {2'b00, cfg.m0_base};
  endfunction

  // Range tests run in 34 bits so that base plus size never wraps.
  function automatic bit hits_module(bit m, bit [33:0] a);
    return (a >= base_of(m)) && (a < base_of(m) + eff_size(m));
  endfunction

  function automatic bit in_hole(bit [33:0] a);
    return (a >= {2'b00, cfg.hole_base}) &&
           (a < {2'b00, cfg.hole_base} + {2'b00, cfg.hole_size});
  endfunction

  function automatic bit [15:0] offset_in(bit m, bit [33:0] a);
    return 16'(a - base_of(m));
  endfunction

  function automatic bit [7:0] fetch_byte(bit m, bit [33:0] a);
    if (!hits_module(m, a)) return 8'h00;
    return mem_bytes[m][offset_in(m, a)];
  endfunction

  function automatic void store_byte(bit m, bit [33:0] a, bit [7:0] v);
    if (cfg.rom[m] || !hits_module(m, a)) return;
    mem_bytes[m][offset_in(m, a)] = v;
    written[m][offset_in(m, a)] = 1'b1;
  endfunction

  // One bus clock of the controller.
  function automatic void memctl_clock(input bus_req_t q, output bus_out_t r);
    bit [33:0] a;
    bit        started;
    started = 1'b0;
    r = '{1'b0, 1'b0, 16'h0000};
    if (bus_phase == bmwsc_pkg::PhReady && (q.rd || q.lanes != 2'b00)) begin
      held_addr  = {q.addr[31:1], 1'b0};
      held_data  = q.data;
      held_lanes = q.lanes;
      a = {2'b00, held_addr};
      if (!in_hole(a)) begin
        for (int i = 0; i < bmwsc_pkg::ModuleCount; i++) begin
          if (!started && hits_module(bit'(i), a)) begin
            started     = 1'b1;
            held_module = bit'(i);
            bus_phase   = q.rd ? bmwsc_pkg::PhRead : bmwsc_pkg::PhWrite;
            wait_cnt    = 8'(cfg.latency >> (i * 16 + (q.rd ? 0 : 8)));
          end
        end
      end
    end
    if (bus_phase == bmwsc_pkg::PhRead || bus_phase == bmwsc_pkg::PhWrite) begin
      if (wait_cnt > 0) begin
        r.nr = 1'b1;
        wait_cnt--;
      end else begin
        a = {2'b00, held_addr};
        if (bus_phase == bmwsc_pkg::PhRead) begin
          r.rdata = {fetch_byte(held_module, a + 34'd1), fetch_byte(held_module, a)};
          r.drive = 1'b1;
        end else begin
          if (held_lanes[0]) store_byte(held_module, a, held_data[7:0]);
          if (held_lanes[1]) store_byte(held_module, a + 34'd1, held_data[15:8]);
        end
        bus_phase = bmwsc_pkg::PhClean;
      end
    end else if (bus_phase == bmwsc_pkg::PhClean) begin
      bus_phase = bmwsc_pkg::PhReady;
    end
  endfunction

  // A read that would reach an unwritten byte becomes a write, both lanes if none.
  function automatic bus_req_t make_safe(bus_req_t q);
    bit [33:0] a;
    bit        found;
    bit        m;
    found = 1'b0;
    m = 1'b0;
    a = {2'b00, q.addr[31:1], 1'b0};
    if (bus_phase == bmwsc_pkg::PhReady && q.rd && !in_hole(a)) begin
      for (int i = 0; i < bmwsc_pkg::ModuleCount; i++) begin
        if (!found && hits_module(bit'(i), a)) begin
          found = 1'b1;
          m = bit'(i);
        end
      end
      if (found && (!written[m][offset_in(m, a)] ||
                    (hits_module(m, a + 34'd1) && !written[m][offset_in(m, a + 34'd1)])))
      begin
        q.rd = 1'b0;
        if (q.lanes == 2'b00) q.lanes = 2'b11;
      end
    end
    return q;
  endfunction

  function automatic bit [31:0] pick_addr();
    bit        m;
    int        sz;
    int        span;
    bit [31:0] b;
    m = $urandom_range(0, 1);
    sz = eff_size(m);
    span = (sz > 256) ? 255 : sz - 1;
    b = 32'(base_of(m));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return (sz == 0) ? $urandom : b + $urandom_range(0, span);
      4, 5:       return (sz == 0) ? $urandom : b + sz - 1 - $urandom_range(0, span);
      6:          return cfg.hole_base + $urandom_range(0, 255);
      7:          return $urandom;
      8:          return b + sz - 3 + $urandom_range(0, 3);
      default:    return b - 2 + $urandom_range(0, 3);
    endcase
  endfunction

  // While a request is in flight most items carry no request, as a bus master
  // would behave; the rest are requests that the controller must ignore.
  function automatic bus_req_t random_req();
    bus_req_t q;
    q.addr = pick_addr();
    q.data = 16'($urandom);
    if ((bus_phase != bmwsc_pkg::PhReady) ? ($urandom_range(0, 4) != 0)
                                          : ($urandom_range(0, 5) == 0))
    begin
      q.rd = 1'b0;
      q.lanes = 2'b00;
    end else begin
      q.rd = ($urandom_range(0, 9) < 5);
      q.lanes = q.rd ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 3));
    end
    return make_safe(q);
  endfunction

  function automatic mem_map_t map_setting(int k);
    case (k)
      0: return '{32'h0, 32'h0, 32'h0, 17'h10000, 32'h0001_0000, 17'h10000,
                  32'h0000_0000, 2'b00};
      1: return '{32'h0001_0800, 32'h200, 32'h0001_0001, 17'h400, 32'h0001_0000, 17'h1000,
                  32'h0302_0100, 2'b00};
      2: return '{32'h0, 32'h0, 32'h0, 17'h10000, 32'hFFFF_0000, 17'h10000,
                  32'h0101_0101, 2'b11};
      3: return '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FC01, 17'h400, 32'h0, 17'h0,
                  32'hFFFF_00FF, 2'b00};
      4: return '{32'h0001_4400, 32'h100, 32'h0000_4000, 17'h10000, 32'h0001_4000, 17'h800,
                  32'h0001_0203, 2'b01};
      default: return '{32'h0000_0010, 32'h0, 32'h0010_0000, 17'h8000, 32'h0010_8000,
                        17'h8000, 32'h0, 2'b10};
    endcase
  endfunction

  function automatic plan_row_t req_row(bit rd, bit [1:0] lanes, bit [31:0] addr,
                                        bit [15:0] data);
    return '{1'b0, bmwsc_pkg::RegIoHoleBase, 32'h0, '{rd, lanes, addr, data}, 1'b0,
             '{1'b0, 1'b0, 16'h0}};
  endfunction

  function automatic plan_row_t ans_row(bit rd, bit [1:0] lanes, bit [31:0] addr,
                                        bit [15:0] data, bit nr, bit drive,
                                        bit [15:0] rdata);
    return '{1'b0, bmwsc_pkg::RegIoHoleBase, 32'h0, '{rd, lanes, addr, data}, 1'b1,
             '{nr, drive, rdata}};
  endfunction

  function automatic plan_row_t reg_row(logic [bmwsc_pkg::CfgIdxW-1:0] idx, bit [31:0] val);
    return '{1'b1, idx, val, '{1'b0, 2'b00, 32'h0, 16'h0}, 1'b0, '{1'b0, 1'b0, 16'h0}};
  endfunction

  // Register writes stay back to back; the caller lowers the write enable.
  task automatic write_reg(logic [bmwsc_pkg::CfgIdxW-1:0] idx, bit [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      bmwsc_pkg::RegIoHoleBase:  cfg.hole_base = val;
      bmwsc_pkg::RegIoHoleSize:  cfg.hole_size = val;
      bmwsc_pkg::RegModule0Base: cfg.m0_base = val;
      bmwsc_pkg::RegModule0Size: cfg.m0_size = val[16:0];
      bmwsc_pkg::RegModule1Base: cfg.m1_base = val;
      bmwsc_pkg::RegModule1Size: cfg.m1_size = val[16:0];
      bmwsc_pkg::RegLatency:     cfg.latency = val;
      bmwsc_pkg::RegRomFlags:    cfg.rom = val[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_map(mem_map_t s);
    write_reg(bmwsc_pkg::RegIoHoleBase, s.hole_base);
    write_reg(bmwsc_pkg::RegIoHoleSize, s.hole_size);
    write_reg(bmwsc_pkg::RegModule0Base, s.m0_base);
    write_reg(bmwsc_pkg::RegModule0Size, {15'b0, s.m0_size});
    write_reg(bmwsc_pkg::RegModule1Base, s.m1_base);
    write_reg(bmwsc_pkg::RegModule1Size, {15'b0, s.m1_size});
    write_reg(bmwsc_pkg::RegLatency, s.latency);
    write_reg(bmwsc_pkg::RegRomFlags, {30'b0, s.rom});
    cfg_we_i <= 1'b0;
  endtask

  // Drives one bus clock and returns what the controller should answer to it.
  task automatic drive_bus_clock(input bus_req_t q, output bus_out_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    read_enable_i <= q.rd;
    write_lanes_i <= q.lanes;
    bus_address_i <= q.addr;
    write_data_i  <= q.data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    memctl_clock(q, r);
  endtask

  // Runs the controller back to ready and lets every result drain.
  task automatic settle_bus();
    bus_req_t idle_req;
    bus_out_t r;
    while (bus_phase != bmwsc_pkg::PhReady) begin
      idle_req = '{1'b0, 2'b00, $urandom, 16'($urandom)};
      drive_bus_clock(idle_req, r);
      queue_result(r);
    end
    if (in_valid_i) in_valid_i <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int       n;
    bus_out_t want;
    wait (rst_ni === 1'b1);
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (awaited_out.size() == 0) begin
        $error("result transfer with no bus clock awaiting it");
        fail_count++;
      end else begin
        want = awaited_out.pop_front();
        if (not_ready_o !== want.nr) begin
          $error("not_ready: expected %0d, actual %0d", want.nr, not_ready_o);
          fail_count++;
        end
        if (data_drive_o !== want.drive) begin
          $error("data_drive: expected %0d, actual %0d", want.drive, data_drive_o);
          fail_count++;
        end
        if (read_data_o !== want.rdata) begin
          $error("read_data: expected %h, actual %h", want.rdata, read_data_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan [PlanRows];
    mem_map_t  s;
    bus_req_t  q;
    bus_out_t  r;
    int        done;
    int        sent;

    // Reset config and zero latency up to the register rows: a request completes
    // in its own clock and the next is cleanup, so the row after it is ignored.
    plan = '{
      ans_row(1'b0, 2'b00, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000),
      req_row(1'b0, 2'b11, 32'h0000_0001, 16'hA55A),
      req_row(1'b1, 2'b00, 32'h0000_0000, 16'h0000),
      ans_row(1'b1, 2'b11, 32'h0000_0001, 16'h0000, 1'b0, 1'b1, 16'hA55A),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b01, 32'h0001_FFFE, 16'h1234),
      req_row(1'b0, 2'b11, 32'h0001_FFFE, 16'hFFFF),
      req_row(1'b0, 2'b10, 32'h0001_FFFF, 16'hABCD),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      ans_row(1'b1, 2'b00, 32'h0001_FFFF, 16'h0000, 1'b0, 1'b1, 16'hAB34),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      ans_row(1'b1, 2'b00, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000),
      req_row(1'b0, 2'b11, 32'h0000_FFFE, 16'hFFFF),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      ans_row(1'b1, 2'b00, 32'h0000_FFFF, 16'h0000, 1'b0, 1'b1, 16'hFFFF),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      reg_row(bmwsc_pkg::RegIoHoleSize, 32'h0000_0100),
      reg_row(bmwsc_pkg::RegLatency, 32'h0000_0201),
      ans_row(1'b1, 2'b00, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000),
      req_row(1'b1, 2'b00, 32'h0000_FFFE, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b11, 32'h0000_0100, 16'h0102),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b1, 2'b00, 32'h0000_0100, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000),
      req_row(1'b0, 2'b00, 32'h0000_0000, 16'h0000)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle_bus();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        drive_bus_clock(plan[i].req, r);
        queue_result(plan[i].typed ? plan[i].out : r);
      end
    end

    sent = 0;
    for (int k = 0; k < PhaseCount; k++) begin
      // Registers only change with the controller ready and nothing in flight.
      settle_bus();
      s = map_setting(k);
      if (k == PhaseCount - 1) s.latency = $urandom & 32'h0303_0303;
      apply_map(s);
      done = 0;
      while (done < PhaseItems) begin
        if (sent % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        q = random_req();
        drive_bus_clock(q, r);
        queue_result(r);
        sent++;
        done++;
      end
    end

    settle_bus();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
